FILE: src/rsc_pkg.sv
// Shared types and constants for the Reed-Solomon syndrome calculator.
// Holds command codes, register indexes, port widths and sequencer control types.
// No dependencies.
`default_nettype none

package rsc_pkg;

   // Widths of the fixed port fields
   localparam int CMD_W        = 2;
   localparam int TBL_IDX_W    = 8;
   localparam int SYM_PORT_W   = 8;
   localparam int SYN_IDX_W    = 4;
   localparam int SYN_COUNT_W  = 5;
   localparam int FIELD_SIZE_W = 9;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 9;

   localparam logic [SYN_COUNT_W-1:0]  SYN_COUNT_RST  = 5'd16;
   localparam logic [FIELD_SIZE_W-1:0] FIELD_SIZE_RST = 9'd256;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOG_WR  = 2'd0,
      CMD_ALOG_WR = 2'd1,
      CMD_DATA    = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYN_COUNT  = 1'b0,
      CSR_FIELD_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAPV,
      ST_RD,
      ST_LP,
      ST_LA,
      ST_AL1,
      ST_AL2,
      ST_WR,
      ST_ORD,
      ST_OLD
   } seq_state_type;

   typedef enum logic [1:0] {
      LOG_SRC_REQ,
      LOG_SRC_POW,
      LOG_SRC_ALPHA
   } log_src_type;

   typedef enum logic [1:0] {
      ALOG_SRC_ALPHA,
      ALOG_SRC_SUM_DATA,
      ALOG_SRC_SUM_POW
   } alog_src_type;

   typedef struct packed {
      logic         log_rd;
      log_src_type  log_src;
      logic         alog_rd;
      alog_src_type alog_src;
      logic         st_rd;
      logic         st_wr;
      logic         cap_lv;
      logic         cap_stage;
      logic         cap_lp;
      logic         cap_la;
      logic         cap_prod;
      logic         out_ld;
      logic         out_last;
      logic         clear_valid;
   } ctl_type;

endpackage

`default_nettype wire

FILE: src/rs_syndrome_calculator.sv
// Reed-Solomon syndrome calculator over GF(2^SYMBOL_BITS). Load the log table
// (cmd 0) and antilog table (cmd 1) first, one entry per beat; table writes do
// not stall the request channel. A data beat (cmd 2) then updates all MAX_SYNDROMES
// accumulators and running powers held in a state RAM, walking them one at a
// time through the single read ports of the two table RAMs. A data beat with
// block_end set then reads out min(syndrome count register, MAX_SYNDROMES)
// syndromes in index order, the last one marked, and the accumulators return to
// zero and the powers to one at once. The request channel stalls while a beat is
// in progress; the last result may still be waiting in the output register while
// the next beat is taken. Write the configuration registers only while the block
// is idle.
`default_nettype none

module rs_syndrome_calculator
   import rsc_pkg::*;
#(
   parameter int SYMBOL_BITS   = 8,
   parameter int MAX_SYNDROMES = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [CMD_W-1:0]        req_cmd,
   input  wire  [TBL_IDX_W-1:0]    req_table_index,
   input  wire  [SYM_PORT_W-1:0]   req_symbol_value,
   input  wire                     req_block_end,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [SYN_IDX_W-1:0]    rsp_syndrome_index,
   output logic [SYM_PORT_W-1:0]   rsp_syndrome_value,
   output logic                    rsp_last_syndrome,
   input  wire                     csr_wr_en,
   input  wire  [CSR_IDX_W-1:0]    csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int SB     = SYMBOL_BITS;
   localparam int TBL_D  = 1 << SB;
   localparam int IDX_W  = (MAX_SYNDROMES > 1) ? $clog2(MAX_SYNDROMES) : 1;
   localparam int SUM_W  = ((SB + 1) > FIELD_SIZE_W) ? (SB + 1) : FIELD_SIZE_W;

   ctl_type                 ctl;
   logic [IDX_W-1:0]        idx;
   logic                    req_acc;
   logic                    out_free;

   logic [SYN_COUNT_W-1:0]  syn_count_ff;
   logic [FIELD_SIZE_W-1:0] gf_order_ff;

   // table RAM ports
   logic                    log_wr, alog_wr;
   logic [SB-1:0]           tbl_wr_addr, tbl_wr_data;
   logic [SB-1:0]           log_rd_addr, alog_rd_addr;
   logic [SB-1:0]           log_rd_data, alog_rd_data;

   // state RAM ports: {accumulator, running power}
   logic [2*SB-1:0]         st_wr_data, st_rd_data;

   logic                    valid_ff [MAX_SYNDROMES];
   logic                    rd_valid_ff;
   logic [SB-1:0]           acc_rd, pow_rd;

   logic [SB-1:0]           val_ff, lv_ff, acc_ff, p_ff, alpha_ff, lp_ff, la_ff, prod_ff;
   logic [SUM_W-1:0]        modulus, sum_dat, sum_pow, red_dat, red_pow;
   logic [IDX_W:0]          idx_p1;
   logic                    zero_dat, zero_pow;
   logic [SB-1:0]           new_acc, new_pow;

   logic                    rsp_valid_ff;
   logic [SYN_IDX_W-1:0]    rsp_index_ff;
   logic [SYM_PORT_W-1:0]   rsp_value_ff;
   logic                    rsp_last_ff;

   rsc_seq #(
      .MAX_SYNDROMES (MAX_SYNDROMES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_cmd       (req_cmd),
      .req_block_end (req_block_end),
      .syn_count     (syn_count_ff),
      .out_free      (out_free),
      .req_stall     (req_stall),
      .idx           (idx),
      .ctl           (ctl)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         syn_count_ff <= SYN_COUNT_RST;
         gf_order_ff  <= FIELD_SIZE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SYN_COUNT:  syn_count_ff <= csr_wr_data[SYN_COUNT_W-1:0];
            CSR_FIELD_SIZE: gf_order_ff  <= csr_wr_data[FIELD_SIZE_W-1:0];
            default:        syn_count_ff <= syn_count_ff;
         endcase
      end
   end

   assign req_acc     = req_valid && !req_stall;
   assign log_wr      = req_acc && (req_cmd == CMD_LOG_WR);
   assign alog_wr     = req_acc && (req_cmd == CMD_ALOG_WR);
   assign tbl_wr_addr = SB'(req_table_index);
   assign tbl_wr_data = SB'(req_symbol_value);

   // log-domain sums, reduced once by the field order minus one
   assign modulus = SUM_W'(gf_order_ff - FIELD_SIZE_W'(1));
   assign sum_dat = SUM_W'(lv_ff) + SUM_W'(lp_ff);
   assign sum_pow = SUM_W'(lp_ff) + SUM_W'(la_ff);
   assign red_dat = (sum_dat >= modulus) ? (sum_dat - modulus) : sum_dat;
   assign red_pow = (sum_pow >= modulus) ? (sum_pow - modulus) : sum_pow;
   assign idx_p1  = {1'b0, idx} + (IDX_W + 1)'(1);

   always_comb begin
      case (ctl.log_src)
         LOG_SRC_POW:   log_rd_addr = pow_rd;
         LOG_SRC_ALPHA: log_rd_addr = alpha_ff;
         default:       log_rd_addr = SB'(req_symbol_value);
      endcase
      case (ctl.alog_src)
         ALOG_SRC_SUM_DATA: alog_rd_addr = red_dat[SB-1:0];
         ALOG_SRC_SUM_POW:  alog_rd_addr = red_pow[SB-1:0];
         default:           alog_rd_addr = SB'(idx_p1);
      endcase
   end

   rsc_ram #(
      .WIDTH (SB),
      .DEPTH (TBL_D)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (log_wr),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (ctl.log_rd),
      .rd_addr (log_rd_addr),
      .rd_data (log_rd_data)
   );

   rsc_ram #(
      .WIDTH (SB),
      .DEPTH (TBL_D)
   ) u_alog_ram (
      .clock   (clock),
      .wr_en   (alog_wr),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (ctl.alog_rd),
      .rd_addr (alog_rd_addr),
      .rd_data (alog_rd_data)
   );

   rsc_ram #(
      .WIDTH (2 * SB),
      .DEPTH (MAX_SYNDROMES)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ctl.st_wr),
      .wr_addr (idx),
      .wr_data (st_wr_data),
      .rd_en   (ctl.st_rd),
      .rd_addr (idx),
      .rd_data (st_rd_data)
   );

   // an entry not written since the last block end reads as zero accumulator, unit power
   assign acc_rd = rd_valid_ff ? st_rd_data[2*SB-1:SB] : '0;
   assign pow_rd = rd_valid_ff ? st_rd_data[SB-1:0]    : SB'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_SYNDROMES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (ctl.clear_valid) begin
         for (int k = 0; k < MAX_SYNDROMES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (ctl.st_wr) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.st_rd) begin
         rd_valid_ff <= valid_ff[idx];
      end
      if (req_acc) begin
         val_ff <= SB'(req_symbol_value);
      end
      if (ctl.cap_lv) begin
         lv_ff <= log_rd_data;
      end
      if (ctl.cap_stage) begin
         acc_ff   <= acc_rd;
         p_ff     <= pow_rd;
         alpha_ff <= alog_rd_data;
      end
      if (ctl.cap_lp) begin
         lp_ff <= log_rd_data;
      end
      if (ctl.cap_la) begin
         la_ff <= log_rd_data;
      end
      if (ctl.cap_prod) begin
         prod_ff <= alog_rd_data;
      end
   end

   // a zero factor forces a zero product
   assign zero_dat   = (val_ff == '0) || (p_ff == '0);
   assign zero_pow   = (p_ff == '0) || (alpha_ff == '0);
   assign new_acc    = acc_ff ^ (zero_dat ? '0 : prod_ff);
   assign new_pow    = zero_pow ? '0 : alog_rd_data;
   assign st_wr_data = {new_acc, new_pow};

   // result register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_ld) begin
         rsp_index_ff <= SYN_IDX_W'(idx);
         rsp_value_ff <= SYM_PORT_W'(acc_rd);
         rsp_last_ff  <= ctl.out_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_syndrome_index = rsp_index_ff;
   assign rsp_syndrome_value = rsp_value_ff;
   assign rsp_last_syndrome  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: src/rsc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data updates only on a read enable and holds otherwise.
// No dependencies.
`default_nettype none

module rsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire                                     clock,
   input  wire                                     wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                        wr_data,
   input  wire                                     rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/rsc_seq.sv
// Sequencer of the syndrome calculator: walks the accumulators per data beat
// and at a block end reads them out for the result channel. Uses rsc_pkg.
`default_nettype none

module rsc_seq
   import rsc_pkg::*;
#(
   parameter int MAX_SYNDROMES = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  wire  [CMD_W-1:0]           req_cmd,
   input  wire                        req_block_end,
   input  wire  [SYN_COUNT_W-1:0]     syn_count,
   input  wire                        out_free,
   output logic                       req_stall,
   output logic [((MAX_SYNDROMES > 1) ? $clog2(MAX_SYNDROMES) : 1)-1:0] idx,
   output ctl_type                    ctl
);

   localparam int IDX_W = (MAX_SYNDROMES > 1) ? $clog2(MAX_SYNDROMES) : 1;
   localparam int CNT_W = $clog2(MAX_SYNDROMES + 1);
   localparam int CMP_W = SYN_COUNT_W + 1;

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic             last_ff, last_in;

   logic             accept_data;
   logic             idx_end;
   logic             emit_last;
   logic [CNT_W-1:0] n_sat;

   assign accept_data = req_valid && (state_ff == ST_IDLE) && (req_cmd == CMD_DATA);
   assign idx_end     = (i_ff == IDX_W'(MAX_SYNDROMES - 1));
   assign n_sat       = ({1'b0, syn_count} > CMP_W'(MAX_SYNDROMES)) ?
                        CNT_W'(MAX_SYNDROMES) : CNT_W'(syn_count);
   assign emit_last   = ((CNT_W'(i_ff) + CNT_W'(1)) == n_sat);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_data) begin
               state_in = ST_CAPV;
            end
         end
         ST_CAPV: state_in = ST_RD;
         ST_RD:   state_in = ST_LP;
         ST_LP:   state_in = ST_LA;
         ST_LA:   state_in = ST_AL1;
         ST_AL1:  state_in = ST_AL2;
         ST_AL2:  state_in = ST_WR;
         ST_WR: begin
            if (!idx_end) begin
               state_in = ST_RD;
            end else if (last_ff && (n_sat != '0)) begin
               state_in = ST_ORD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ORD:  state_in = ST_OLD;
         ST_OLD: begin
            if (out_free) begin
               state_in = emit_last ? ST_IDLE : ST_ORD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // counter and block-end flag
   always_comb begin
      i_in    = i_ff;
      last_in = accept_data ? req_block_end : last_ff;
      if (state_ff == ST_WR) begin
         i_in = idx_end ? '0 : i_ff + IDX_W'(1);
      end else if ((state_ff == ST_OLD) && out_free) begin
         i_in = emit_last ? '0 : i_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         last_ff  <= last_in;
      end
   end

   // outputs
   always_comb begin
      ctl          = '0;
      ctl.log_src  = LOG_SRC_REQ;
      ctl.alog_src = ALOG_SRC_ALPHA;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.log_rd = accept_data;
         end
         ST_CAPV: begin
            ctl.cap_lv = 1'b1;
         end
         ST_RD: begin
            ctl.st_rd   = 1'b1;
            ctl.alog_rd = 1'b1;
         end
         ST_LP: begin
            ctl.cap_stage = 1'b1;
            ctl.log_rd    = 1'b1;
            ctl.log_src   = LOG_SRC_POW;
         end
         ST_LA: begin
            ctl.cap_lp  = 1'b1;
            ctl.log_rd  = 1'b1;
            ctl.log_src = LOG_SRC_ALPHA;
         end
         ST_AL1: begin
            ctl.cap_la   = 1'b1;
            ctl.alog_rd  = 1'b1;
            ctl.alog_src = ALOG_SRC_SUM_DATA;
         end
         ST_AL2: begin
            ctl.cap_prod = 1'b1;
            ctl.alog_rd  = 1'b1;
            ctl.alog_src = ALOG_SRC_SUM_POW;
         end
         ST_WR: begin
            ctl.st_wr       = 1'b1;
            ctl.clear_valid = idx_end && last_ff && (n_sat == '0);
         end
         ST_ORD: begin
            ctl.st_rd = 1'b1;
         end
         ST_OLD: begin
            ctl.out_ld      = out_free;
            ctl.out_last    = emit_last;
            ctl.clear_valid = out_free && emit_last;
         end
         default: begin
            ctl.log_rd = 1'b0;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign idx       = i_ff;

endmodule

`default_nettype wire

FILE: tb/sv/rs_syndrome_monitor.sv
`timescale 1ns / 100ps
// Scoreboard for rs_syndrome_calculator: mirrors the table, accumulator and power state,
// predicts the syndrome beats of each block and compares them in order.
// Depends on rsc_pkg for port widths, command codes and register indexes.

module rs_syndrome_monitor
   import rsc_pkg::*;
#(
   parameter int MAX_SYNDROMES = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_stall,
   input  wire  [CMD_W-1:0]        req_cmd,
   input  wire  [TBL_IDX_W-1:0]    req_table_index,
   input  wire  [SYM_PORT_W-1:0]   req_symbol_value,
   input  wire                     req_block_end,
   input  wire                     rsp_valid,
   input  wire                     rsp_stall,
   input  wire  [SYN_IDX_W-1:0]    rsp_syndrome_index,
   input  wire  [SYM_PORT_W-1:0]   rsp_syndrome_value,
   input  wire                     rsp_last_syndrome,
   input  wire                     csr_wr_en,
   input  wire  [CSR_IDX_W-1:0]    csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_wr_data,
   output logic [31:0]             fail_count,
   output logic [31:0]             pending_count
);

   localparam int TABLE_DEPTH = 2 ** SYM_PORT_W;

   typedef struct packed {
      logic [SYN_IDX_W-1:0]  syn_index;
      logic [SYM_PORT_W-1:0] syn_value;
      logic                  syn_last;
   } syndrome_beat_type;

   syndrome_beat_type       expected_syndromes[$];
   syndrome_beat_type       oldest;
   logic [SYM_PORT_W-1:0]   log_mirror    [TABLE_DEPTH];
   logic [SYM_PORT_W-1:0]   alog_mirror   [TABLE_DEPTH];
   logic [SYM_PORT_W-1:0]   syndrome_acc  [MAX_SYNDROMES];
   logic [SYM_PORT_W-1:0]   running_power [MAX_SYNDROMES];
   logic [SYN_COUNT_W-1:0]  syn_count;
   logic [FIELD_SIZE_W-1:0] gf_order;
   int                      mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string msg);
      $display("%0t: syndrome mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Table product; the log sum is reduced at most once.
   function automatic logic [SYM_PORT_W-1:0] field_mul(input logic [SYM_PORT_W-1:0] a,
                                                       input logic [SYM_PORT_W-1:0] b);
      logic [SYM_PORT_W+1:0]   log_sum;
      logic [FIELD_SIZE_W-1:0] modulus;
      if (a == '0 || b == '0)
         return '0;
      log_sum = {2'b00, log_mirror[a]} + {2'b00, log_mirror[b]};
      modulus = gf_order - FIELD_SIZE_W'(1);
      if (log_sum >= {1'b0, modulus})
         log_sum = log_sum - {1'b0, modulus};
      return alog_mirror[log_sum[SYM_PORT_W-1:0]];
   endfunction

   task automatic clear_block();
      for (int k = 0; k < MAX_SYNDROMES; k++) begin
         syndrome_acc[k] = '0;
         running_power[k] = SYM_PORT_W'(1);
      end
   endtask

   task automatic predict_beat(input logic [CMD_W-1:0] cmd, input logic [TBL_IDX_W-1:0] addr,
                               input logic [SYM_PORT_W-1:0] sym, input logic block_end);
      logic [SYM_PORT_W-1:0] alpha;
      logic [SYM_PORT_W-1:0] power;
      syndrome_beat_type     entry;
      int                    emit_count;
      case (cmd)
         CMD_LOG_WR: begin
            log_mirror[addr] = sym;
         end
         CMD_ALOG_WR: begin
            alog_mirror[addr] = sym;
         end
         CMD_DATA: begin
            for (int k = 0; k < MAX_SYNDROMES; k++) begin
               alpha = alog_mirror[SYM_PORT_W'(k + 1)];
               power = running_power[k];
               syndrome_acc[k] = syndrome_acc[k] ^ field_mul(sym, power);
               running_power[k] = field_mul(power, alpha);
            end
            if (block_end) begin
               emit_count = (syn_count > MAX_SYNDROMES) ? MAX_SYNDROMES : syn_count;
               for (int k = 0; k < emit_count; k++) begin
                  entry.syn_index = SYN_IDX_W'(k);
                  entry.syn_value = syndrome_acc[k];
                  entry.syn_last  = (k == emit_count - 1);
                  expected_syndromes.push_back(entry);
               end
               clear_block();
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_syndromes.delete();
         syn_count = SYN_COUNT_RST;
         gf_order = FIELD_SIZE_RST;
         clear_block();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_SYN_COUNT)
               syn_count = csr_wr_data[SYN_COUNT_W-1:0];
            else
               gf_order = csr_wr_data[FIELD_SIZE_W-1:0];
         end
         if (req_valid && !req_stall)
            predict_beat(req_cmd, req_table_index, req_symbol_value, req_block_end);
         if (rsp_valid && !rsp_stall) begin
            if (expected_syndromes.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, index %0d value %0h",
                                         rsp_syndrome_index, rsp_syndrome_value));
            end else begin
               oldest = expected_syndromes.pop_front();
               if (rsp_syndrome_index !== oldest.syn_index)
                  report_mismatch($sformatf("index got %0d expected %0d",
                                            rsp_syndrome_index, oldest.syn_index));
               if (rsp_syndrome_value !== oldest.syn_value)
                  report_mismatch($sformatf("syndrome %0d value got %0h expected %0h",
                                            oldest.syn_index, rsp_syndrome_value,
                                            oldest.syn_value));
               if (rsp_last_syndrome !== oldest.syn_last)
                  report_mismatch($sformatf("syndrome %0d last flag got %0b expected %0b",
                                            oldest.syn_index, rsp_last_syndrome,
                                            oldest.syn_last));
            end
         end
      end
      pending_count <= expected_syndromes.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the rs_syndrome_calculator testbench: loads GF(2^8) tables, drives directed and
// random symbol blocks across several register settings and gives the verdict.
// Depends on rsc_pkg, rs_syndrome_calculator and rs_syndrome_monitor.

module tb_top;
   import rsc_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RESERVED   = 2'd3;
   localparam logic [7:0]       GF_POLY_LOW    = 8'h1D;
   localparam int               SETTLE_CYCLES  = 2 * (2 + 6 * 16);
   localparam int               HOLD_CYCLES    = 2000;
   localparam int               PHASES         = 10;
   localparam int               ITEMS_PER_PHASE = 48;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_cmd = CMD_DATA;
   logic [TBL_IDX_W-1:0]    req_table_index = '0;
   logic [SYM_PORT_W-1:0]   req_symbol_value = '0;
   logic                    req_block_end = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [SYN_IDX_W-1:0]    rsp_syndrome_index;
   logic [SYM_PORT_W-1:0]   rsp_syndrome_value;
   logic                    rsp_last_syndrome;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_SYN_COUNT;
   logic [CSR_DATA_W-1:0]   csr_wr_data = '0;
   logic [31:0]             fail_count;
   logic [31:0]             pending_count;

   logic [7:0] gf_log  [256];
   logic [7:0] gf_alog [256];
   int         burst_left = 0;
   bit         sender_idles = 1'b1;
   int         hold_requests = 0;

   rs_syndrome_calculator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_table_index    (req_table_index),
      .req_symbol_value   (req_symbol_value),
      .req_block_end      (req_block_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_syndrome_index (rsp_syndrome_index),
      .rsp_syndrome_value (rsp_syndrome_value),
      .rsp_last_syndrome  (rsp_last_syndrome),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   rs_syndrome_monitor syndrome_mon (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_table_index    (req_table_index),
      .req_symbol_value   (req_symbol_value),
      .req_block_end      (req_block_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_syndrome_index (rsp_syndrome_index),
      .rsp_syndrome_value (rsp_syndrome_value),
      .rsp_last_syndrome  (rsp_last_syndrome),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Offer one beat and hold it until accepted; between bursts, sometimes idle.
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [TBL_IDX_W-1:0] addr,
                            input logic [SYM_PORT_W-1:0] sym, input logic block_end);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = 0;
         if (sender_idles && $urandom_range(2) != 0)
            gap = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_table_index  <= addr;
      req_symbol_value <= sym;
      req_block_end    <= block_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid, wait for every outstanding syndrome, then let the block go quiet.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [SYN_COUNT_W-1:0] count,
                             input logic [FIELD_SIZE_W-1:0] fsize);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SYN_COUNT;
      // upper bits of the count write are don't-care
      csr_wr_data <= {4'($urandom_range(15)), count};
      @(posedge clock);
      csr_index   <= CSR_FIELD_SIZE;
      csr_wr_data <= fsize;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : receiver_pattern
      int stall_pct;
      int mode_left;
      int holds_done;
      stall_pct = 0;
      mode_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            case ($urandom_range(3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         mode_left--;
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin : stimulus
      logic [7:0]              elem;
      logic [7:0]              addr;
      logic [7:0]              sym;
      logic [SYN_COUNT_W-1:0]  syn_count;
      logic [FIELD_SIZE_W-1:0] fsize;
      int                      items_sent;
      int                      block_len;

      // GF(2^8) with x^8 + x^4 + x^3 + x^2 + 1
      elem = 8'd1;
      for (int k = 0; k < 255; k++) begin
         gf_alog[k] = elem;
         gf_log[elem] = 8'(k);
         elem = {elem[6:0], 1'b0} ^ (elem[7] ? GF_POLY_LOW : 8'h00);
      end
      gf_alog[255] = 8'd1;
      gf_log[0] = 8'd0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // Fill both tables completely; block_end on these beats must be ignored.
      for (int a = 0; a < 256; a++)
         send_beat(CMD_LOG_WR, 8'(a), gf_log[a], 1'($urandom_range(1)));
      for (int a = 0; a < 256; a++)
         send_beat(CMD_ALOG_WR, 8'(a), gf_alog[a], 1'($urandom_range(1)));

      // Directed blocks at the reset settings.
      send_beat(CMD_DATA, 8'h00, 8'h00, 1'b1);
      send_beat(CMD_DATA, 8'hFF, 8'hFF, 1'b1);
      send_beat(CMD_DATA, 8'h00, 8'h01, 1'b0);
      send_beat(CMD_DATA, 8'hFF, 8'h80, 1'b0);
      send_beat(CMD_RESERVED, 8'hFF, 8'hFF, 1'b1);
      send_beat(CMD_LOG_WR, 8'h02, gf_log[2], 1'b1);
      send_beat(CMD_ALOG_WR, 8'h01, gf_alog[1], 1'b1);
      send_beat(CMD_DATA, 8'h55, 8'h00, 1'b0);
      send_beat(CMD_DATA, 8'hAA, 8'hFF, 1'b0);
      send_beat(CMD_DATA, 8'h00, 8'hAA, 1'b1);
      send_beat(CMD_RESERVED, 8'h00, 8'h00, 1'b0);
      send_beat(CMD_DATA, 8'h00, 8'h02, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin syn_count = 16; fsize = 256; end
            1: begin syn_count = 1;  fsize = 256; end
            2: begin syn_count = 31; fsize = 256; end
            3: begin syn_count = 0;  fsize = 256; end
            4: begin syn_count = 16; fsize = 0;   end
            5: begin syn_count = 7;  fsize = 1;   end
            6: begin syn_count = 17; fsize = 2;   end
            7: begin syn_count = 16; fsize = 511; end
            default: begin
               syn_count = 5'($urandom_range(31));
               fsize = $urandom_range(1) ? 9'd256 : 9'($urandom_range(511));
            end
         endcase
         set_config(syn_count, fsize);
         sender_idles = (p != 4);
         burst_left = 0;
         // long receiver hold-off while beats keep coming
         if (p == 0)
            hold_requests <= hold_requests + 1;
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE) begin
            block_len = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int j = 0; j < block_len; j++) begin
               // noise inside a block: unused command or a table rewrite
               if ($urandom_range(15) == 0) begin
                  addr = 8'($urandom_range(255));
                  if ($urandom_range(1)) begin
                     send_beat(CMD_RESERVED, addr, 8'($urandom_range(255)),
                               1'($urandom_range(1)));
                  end else begin
                     if ($urandom_range(1))
                        send_beat(CMD_LOG_WR, addr,
                                  ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : gf_log[addr],
                                  1'($urandom_range(1)));
                     else
                        send_beat(CMD_ALOG_WR, addr,
                                  ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : gf_alog[addr],
                                  1'($urandom_range(1)));
                     items_sent++;
                  end
               end
               case ($urandom_range(9))
                  0: sym = 8'h00;
                  1: sym = 8'hFF;
                  default: sym = 8'($urandom_range(255));
               endcase
               send_beat(CMD_DATA, 8'($urandom_range(255)), sym, j == block_len - 1);
               items_sent++;
            end
            if ($urandom_range(11) == 0)
               wait_drained();
         end
      end

      wait_drained();
      if (fail_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
